>>> design/lsbp_pkg.sv
// ----------------------------------------------------------------------------
// lsbp_pkg: shared types and constants for the line sensor block
// Word layouts, register indexes, fixed levels and the lane weights.
// ----------------------------------------------------------------------------
package lsbp_pkg;

    // Sensor geometry
    localparam int NUM_SENSORS = 5;
    localparam int SENSOR_W    = 10;
    localparam int MID_FIRST   = 1;
    localparam int MID_LAST    = 3;

    // Hold counters and timing
    localparam int COUNT_BITS = 16;
    localparam int HOLD_W     = 16;
    localparam int CMP_W      = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

    // Config register fields
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Position arithmetic
    localparam int POS_W      = 12;
    localparam int WEIGHT_W   = 13;
    localparam int TERM_W     = 23;
    localparam int SUM_W      = 12;
    localparam int WEIGHT_STEP = 1000;

    localparam logic [SENSOR_W-1:0] SEEN_LEVEL  = SENSOR_W'(200);
    localparam logic [SENSOR_W-1:0] NOISE_LEVEL = SENSOR_W'(50);
    localparam logic [POS_W-1:0]    CENTRE_POS  = POS_W'((NUM_SENSORS - 1) * 1000 / 2);
    localparam logic [POS_W-1:0]    MAX_POS     = POS_W'((NUM_SENSORS - 1) * 1000);

    // Reset values of the config registers
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(250);
    localparam logic [LEVEL_W-1:0] DEADZONE_RST  = LEVEL_W'(100);
    localparam logic [HOLD_W-1:0]  HOLD_TIME_RST = HOLD_W'(35);

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = CFG_IDX_W'(2);

    // Input word: one scan
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_0;
        logic [SENSOR_W-1:0] sensor_1;
        logic [SENSOR_W-1:0] sensor_2;
        logic [SENSOR_W-1:0] sensor_3;
        logic [SENSOR_W-1:0] sensor_4;
        logic                clear_warnings;
    } in_word_t;

    // Output word: flags and position
    typedef struct packed {
        logic             left_flag;
        logic             right_flag;
        logic             intersection;
        logic             line_seen;
        logic [POS_W-1:0] position;
    } out_word_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [TERM_W-1:0]     term;
        logic [SENSOR_W-1:0]   gated;
        logic                  seen;
    } lane_out_t;

    // Position weight of a lane; outer lanes take no part in the average
    function automatic logic [WEIGHT_W-1:0] lane_weight(input int idx);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        if (idx >= MID_FIRST && idx <= MID_LAST)
        begin
            w = WEIGHT_W'(idx * WEIGHT_STEP);
        end
        return w;
    endfunction

endpackage

>>> design/lsbp_lane.sv
// ----------------------------------------------------------------------------
// lsbp_lane: one sensor lane
// Hysteresis hold counter plus the noise-gated weighted term of the reading.
// ----------------------------------------------------------------------------
module lsbp_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [lsbp_pkg::SENSOR_W-1:0]  value,
    input  logic [lsbp_pkg::WEIGHT_W-1:0]  weight,
    input  logic [lsbp_pkg::LEVEL_W:0]     dark_at,
    input  logic [15:0]                    light_below,
    output lsbp_pkg::lane_out_t            result
);
    import lsbp_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [TERM_W-1:0]     term_reg;
    logic [SENSOR_W-1:0]   gated_reg;
    logic                  seen_reg;
    logic                  is_dark;
    logic                  is_light;
    logic                  over_noise;

    // Hysteresis tests; clearing wins over counting
    assign is_dark    = ({1'b0, value} >= dark_at);
    assign is_light   = (16'(value) < light_below);
    assign over_noise = (value > NOISE_LEVEL);

    always_comb
    begin
        count_next = count_reg;
        if (is_dark && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        if (is_light)
        begin
            count_next = '0;
        end
    end

    // Hold counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= count_next;
        end
    end

    // Weighted term for the position average
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg  <= over_noise ? (TERM_W'(value) * TERM_W'(weight)) : '0;
            gated_reg <= over_noise ? value : '0;
            seen_reg  <= (value > SEEN_LEVEL);
        end
    end

    assign result.count = count_reg;
    assign result.term  = term_reg;
    assign result.gated = gated_reg;
    assign result.seen  = seen_reg;

endmodule

>>> design/lsbp_div.sv
// ----------------------------------------------------------------------------
// lsbp_div: iterative restoring divider
// One quotient bit a cycle; quotient truncated to the position width.
// ----------------------------------------------------------------------------
module lsbp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lsbp_pkg::TERM_W-1:0]  dividend,
    input  logic [lsbp_pkg::SUM_W-1:0]   divisor,
    output logic                         done,
    output logic [lsbp_pkg::POS_W-1:0]   quotient
);
    import lsbp_pkg::*;

    localparam int STEP_W = $clog2(TERM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TERM_W - 1);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t         state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               done_reg;
    logic [TERM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   dsr_reg;
    logic [SUM_W:0]     shifted;
    logic [SUM_W+1:0]   trial;
    logic               q_bit;
    logic [SUM_W-1:0]   rem_next;

    // One restoring step
    assign shifted  = {rem_reg, quo_reg[TERM_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign q_bit    = ~trial[SUM_W+1];
    assign rem_next = q_bit ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DIV_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= '0;
                        state_reg <= DIV_RUN;
                    end
                end
                DIV_RUN:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DIV_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (state_reg == DIV_RUN)
        begin
            quo_reg <= {quo_reg[TERM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[POS_W-1:0];

endmodule

>>> design/line_sensor_boundary_and_position_core.sv
// ----------------------------------------------------------------------------
// line_sensor_boundary_and_position_core: boundary flags and line position
// The result word follows the merge state, the bit-serial divider and the
// hand-over state when the line is seen; when the line is lost the divider
// is skipped. A new scan is taken only once the result word of the last one
// is in the output register. Reset clears counters, flags, last position
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_sensor_boundary_and_position_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lsbp_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lsbp_pkg::out_word_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [LEVEL_W-1:0]  threshold_reg;
    logic [LEVEL_W-1:0]  deadzone_reg;
    logic [HOLD_W-1:0]   hold_time_reg;
    logic                left_reg;
    logic                right_reg;
    logic                both_reg;
    logic                line_reg;
    logic                clear_reg;
    logic [POS_W-1:0]    last_pos_reg;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    logic                accept;
    logic [LEVEL_W:0]    dark_at;
    logic [15:0]         light_below;
    logic [SENSOR_W-1:0] sensor_val [NUM_SENSORS];
    lane_out_t           lane_res   [NUM_SENSORS];
    logic                left_hit;
    logic                right_hit;
    logic                line_now;
    logic [TERM_W-1:0]   avg_sum;
    logic [SUM_W-1:0]    val_sum;
    logic                div_start;
    logic                div_done;
    logic [POS_W-1:0]    div_quo;
    logic [POS_W-1:0]    lost_pos;

    // Handshakes
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Hysteresis levels
    assign dark_at     = {1'b0, threshold_reg} + {1'b0, deadzone_reg};
    assign light_below = 16'(threshold_reg) - 16'(deadzone_reg);

    assign sensor_val[0] = in_data.sensor_0;
    assign sensor_val[1] = in_data.sensor_1;
    assign sensor_val[2] = in_data.sensor_2;
    assign sensor_val[3] = in_data.sensor_3;
    assign sensor_val[4] = in_data.sensor_4;

    // Sensor lanes
    for (genvar g_lane = 0; g_lane < NUM_SENSORS; g_lane++)
    begin : g_lanes
        lsbp_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (accept),
            .value       (sensor_val[g_lane]),
            .weight      (lane_weight(g_lane)),
            .dark_at     (dark_at),
            .light_below (light_below),
            .result      (lane_res[g_lane])
        );
    end

    // Merge: boundary hits, line test and position sums
    assign left_hit  = CMP_W'(lane_res[0].count) > CMP_W'(hold_time_reg);
    assign right_hit = CMP_W'(lane_res[NUM_SENSORS-1].count) > CMP_W'(hold_time_reg);

    always_comb
    begin
        line_now = 1'b0;
        avg_sum  = '0;
        val_sum  = '0;
        for (int i = MID_FIRST; i <= MID_LAST; i++)
        begin
            line_now = line_now | lane_res[i].seen;
            avg_sum  = avg_sum + lane_res[i].term;
            val_sum  = val_sum + SUM_W'(lane_res[i].gated);
        end
    end

    assign div_start = (state_reg == ST_MERGE) && line_now && (val_sum != '0);
    assign lost_pos  = (last_pos_reg < CENTRE_POS) ? '0 : MAX_POS;

    lsbp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (avg_sum),
        .divisor  (val_sum),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Clear request travels with the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clear_reg <= in_data.clear_warnings;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            deadzone_reg  <= DEADZONE_RST;
            hold_time_reg <= HOLD_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                REG_DEADZONE:  deadzone_reg  <= cfg_data[LEVEL_W-1:0];
                REG_HOLD_TIME: hold_time_reg <= cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer, sticky flags and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
            both_reg      <= 1'b0;
            line_reg      <= 1'b0;
            last_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // in ST_DONE the hand-over below owns the valid flag
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    left_reg  <= (left_reg  && !clear_reg) || left_hit;
                    right_reg <= (right_reg && !clear_reg) || right_hit;
                    both_reg  <= (both_reg  && !clear_reg) || (left_hit && right_hit);
                    line_reg  <= div_start;
                    state_reg <= div_start ? ST_DIV : ST_DONE;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.left_flag    <= left_reg;
                        out_data_reg.right_flag   <= right_reg;
                        out_data_reg.intersection <= left_reg && right_reg && both_reg;
                        out_data_reg.line_seen    <= line_reg;
                        out_data_reg.position     <= line_reg ? div_quo : lost_pos;
                        if (line_reg)
                        begin
                            last_pos_reg <= div_quo;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
